### design/tpt_pkg.sv
// Shared types, constants and helper functions for the two-class perceptron trainer.
// Used by tpt_ctrl, tpt_datapath and two_class_perceptron_trainer.
`timescale 1ns / 1ps

package tpt_pkg;

    localparam int MAX_PER_CLASS = 64;
    localparam int FEATURES      = 4;
    localparam int WEIGHT_BITS   = 32;
    localparam int FEAT_BITS     = 8;
    localparam int SLOTS         = FEATURES + 1;
    localparam int IDX_W         = $clog2(MAX_PER_CLASS);
    localparam int CNT_W         = IDX_W + 1;
    localparam int SLOT_W        = 3;
    localparam int ADDR_W        = IDX_W + 1;
    localparam int SAMPLE_W      = FEATURES * FEAT_BITS;
    localparam int DIFF_W        = WEIGHT_BITS + 1;
    localparam int PROD_W        = DIFF_W + FEAT_BITS + 1;
    localparam int ACC_W         = PROD_W + $clog2(SLOTS);
    localparam int RATE_W        = 8;
    localparam int DELTA_W       = RATE_W + FEAT_BITS;
    localparam int SUM_W         = WEIGHT_BITS + 2;
    localparam int EPOCH_W       = 16;
    localparam int SPC_W         = 7;
    localparam int INIT_W        = 16;

    localparam logic [FEAT_BITS-1:0] BIAS_INPUT = FEAT_BITS'(10);
    localparam logic [SLOT_W-1:0]    LAST_SLOT  = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]     MAX_N      = CNT_W'(MAX_PER_CLASS);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic CLASS_FIRST  = 1'b0;
    localparam logic CLASS_SECOND = 1'b1;

    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_MAX_EPOCHS  = 3'd0;
    localparam logic [2:0] REG_SAMPLES     = 3'd1;
    localparam logic [2:0] REG_INIT_FIRST  = 3'd2;
    localparam logic [2:0] REG_INIT_SECOND = 3'd3;
    localparam logic [2:0] REG_RATE        = 3'd4;

    typedef struct packed {
        logic                 command;
        logic                 sample_class;
        logic [IDX_W-1:0]     sample_index;
        logic [FEAT_BITS-1:0] feature_a;
        logic [FEAT_BITS-1:0] feature_b;
        logic [FEAT_BITS-1:0] feature_c;
        logic [FEAT_BITS-1:0] feature_d;
    } in_item_t;

    typedef struct packed {
        logic                          converged;
        logic [EPOCH_W-1:0]            epoch_count;
        logic [SLOT_W-1:0]             weight_slot;
        logic signed [WEIGHT_BITS-1:0] first_weight;
        logic signed [WEIGHT_BITS-1:0] second_weight;
        logic                          last_result;
    } out_item_t;

    typedef struct packed {
        logic               load_wr;
        logic               mem_rd;
        logic               cls;
        logic [IDX_W-1:0]   idx;
        logic [SLOT_W-1:0]  slot;
        logic               init_w;
        logic               acc_clr;
        logic               mul_en;
        logic               acc_en;
        logic               upd_en;
        logic               out_load;
        logic               conv;
        logic [EPOCH_W-1:0] epoch;
    } tpt_cmd_t;

    typedef struct packed {
        logic acc_pos;
        logic acc_neg;
    } tpt_status_t;

    function automatic logic [FEAT_BITS-1:0] aug_input(
        input logic [SAMPLE_W-1:0] sample,
        input logic [SLOT_W-1:0]   slot
    );
        logic [FEAT_BITS-1:0] x;
        case (slot)
            3'd0:    x = BIAS_INPUT;
            3'd1:    x = sample[4*FEAT_BITS-1:3*FEAT_BITS];
            3'd2:    x = sample[3*FEAT_BITS-1:2*FEAT_BITS];
            3'd3:    x = sample[2*FEAT_BITS-1:FEAT_BITS];
            3'd4:    x = sample[FEAT_BITS-1:0];
            default: x = '0;
        endcase
        return x;
    endfunction

    function automatic logic signed [WEIGHT_BITS-1:0] sat_weight(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [WEIGHT_BITS-1:0] r;
        hi = $signed({3'b000, {(WEIGHT_BITS-1){1'b1}}});
        lo = $signed({3'b111, {(WEIGHT_BITS-1){1'b0}}});
        if (v > hi)
            r = hi[WEIGHT_BITS-1:0];
        else if (v < lo)
            r = lo[WEIGHT_BITS-1:0];
        else
            r = v[WEIGHT_BITS-1:0];
        return r;
    endfunction

endpackage

### design/tpt_datapath.sv
// Datapath: sample memory, weight vectors, multiply-accumulate and output register.
// Driven by tpt_ctrl through tpt_cmd_t; depends on tpt_pkg.
`timescale 1ns / 1ps

module tpt_datapath
    import tpt_pkg::*;
(
    input  logic                     clk,
    input  tpt_cmd_t                 cmd,
    input  in_item_t                 in_item,
    input  logic [RATE_W-1:0]        rate_mult,
    input  logic signed [INIT_W-1:0] init_first_weight,
    input  logic signed [INIT_W-1:0] init_second_weight,
    output tpt_status_t              status,
    output out_item_t                out_item
);

    logic [SAMPLE_W-1:0] mem [2*MAX_PER_CLASS];
    logic [SAMPLE_W-1:0] sample_reg;

    logic signed [WEIGHT_BITS-1:0] first_reg  [SLOTS];
    logic signed [WEIGHT_BITS-1:0] second_reg [SLOTS];

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    out_item_t                out_reg;

    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic [FEAT_BITS-1:0]     x_sel;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_next;

    logic signed [WEIGHT_BITS-1:0] first_next  [SLOTS];
    logic signed [WEIGHT_BITS-1:0] second_next [SLOTS];

    assign wr_addr = {in_item.sample_class, in_item.sample_index};
    assign rd_addr = {cmd.cls, cmd.idx};

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            mem[wr_addr] <= {in_item.feature_a, in_item.feature_b,
                             in_item.feature_c, in_item.feature_d};
        end
        if (cmd.mem_rd)
        begin
            sample_reg <= mem[rd_addr];
        end
    end

    assign x_sel     = aug_input(sample_reg, cmd.slot);
    assign diff      = DIFF_W'(first_reg[cmd.slot]) - DIFF_W'(second_reg[cmd.slot]);
    assign prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, x_sel}));

    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            logic [DELTA_W-1:0]     delta;
            logic signed [SUM_W-1:0] d_ext;
            logic signed [SUM_W-1:0] f_sum;
            logic signed [SUM_W-1:0] s_sum;
            delta = DELTA_W'(rate_mult) * DELTA_W'(aug_input(sample_reg, SLOT_W'(j)));
            d_ext = $signed({{(SUM_W-DELTA_W){1'b0}}, delta});
            if (cmd.cls == CLASS_FIRST)
            begin
                f_sum = SUM_W'(first_reg[j]) + d_ext;
                s_sum = SUM_W'(second_reg[j]) - d_ext;
            end
            else
            begin
                f_sum = SUM_W'(first_reg[j]) - d_ext;
                s_sum = SUM_W'(second_reg[j]) + d_ext;
            end
            first_next[j]  = sat_weight(f_sum);
            second_next[j] = sat_weight(s_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            if (cmd.init_w)
            begin
                first_reg[j]  <= WEIGHT_BITS'(init_first_weight);
                second_reg[j] <= WEIGHT_BITS'(init_second_weight);
            end
            else if (cmd.upd_en)
            begin
                first_reg[j]  <= first_next[j];
                second_reg[j] <= second_next[j];
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.out_load)
        begin
            out_reg.converged     <= cmd.conv;
            out_reg.epoch_count   <= cmd.epoch;
            out_reg.weight_slot   <= cmd.slot;
            out_reg.first_weight  <= first_reg[cmd.slot];
            out_reg.second_weight <= second_reg[cmd.slot];
            out_reg.last_result   <= (cmd.slot == LAST_SLOT);
        end
    end

    assign status.acc_pos = !acc_reg[ACC_W-1] && (acc_reg != '0);
    assign status.acc_neg = acc_reg[ACC_W-1];
    assign out_item       = out_reg;

endmodule

### design/tpt_ctrl.sv
// Controller: sequences loads, training epochs and the result drain.
// Drives tpt_datapath through tpt_cmd_t; depends on tpt_pkg.
`timescale 1ns / 1ps

module tpt_ctrl
    import tpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_command,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  logic [EPOCH_W-1:0] max_epochs,
    input  logic [SPC_W-1:0]   samples_per_class,
    input  tpt_status_t        status,
    output tpt_cmd_t           cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_READ,
        S_MUL,
        S_ACC,
        S_DECIDE,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic               cls_reg, cls_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               err_reg, err_next;
    logic               conv_reg, conv_next;
    logic               out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]   n_eff;
    logic               last_sample;
    logic               wrong;
    logic               err_now;
    logic [EPOCH_W:0]   epoch_inc;

    assign n_eff       = (CNT_W'(samples_per_class) > MAX_N) ? MAX_N
                                                             : CNT_W'(samples_per_class);
    assign last_sample = ({1'b0, idx_reg} == (n_eff - CNT_W'(1)));
    assign wrong       = (cls_reg == CLASS_FIRST) ? !status.acc_pos : !status.acc_neg;
    assign err_now     = err_reg | wrong;
    assign epoch_inc   = {1'b0, epoch_reg} + (EPOCH_W+1)'(1);

    always_comb
    begin
        state_next = state_reg;
        cls_next   = cls_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        epoch_next = epoch_reg;
        err_next   = err_reg;
        conv_next  = conv_reg;
        in_ready   = 1'b0;

        cmd          = '0;
        cmd.cls      = cls_reg;
        cmd.idx      = idx_reg;
        cmd.slot     = slot_reg;
        cmd.conv     = conv_reg;
        cmd.epoch    = epoch_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_command == CMD_LOAD)
                        cmd.load_wr = 1'b1;
                    else
                        state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init_w = 1'b1;
                epoch_next = '0;
                err_next   = 1'b0;
                cls_next   = CLASS_FIRST;
                idx_next   = '0;
                slot_next  = '0;
                if (max_epochs == '0)
                begin
                    conv_next  = 1'b0;
                    state_next = S_OUT;
                end
                else if (n_eff == '0)
                begin
                    conv_next  = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.acc_clr = 1'b1;
                slot_next   = '0;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.acc_en = (slot_reg != '0);
                if (slot_reg == LAST_SLOT)
                    state_next = S_ACC;
                else
                    slot_next = slot_reg + SLOT_W'(1);
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.upd_en = wrong;
                slot_next  = '0;
                if (!last_sample)
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    err_next   = err_now;
                    state_next = S_READ;
                end
                else if (cls_reg == CLASS_FIRST)
                begin
                    cls_next   = CLASS_SECOND;
                    idx_next   = '0;
                    err_next   = err_now;
                    state_next = S_READ;
                end
                else if (!err_now)
                begin
                    conv_next  = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    epoch_next = epoch_inc[EPOCH_W-1:0];
                    if (epoch_inc >= {1'b0, max_epochs})
                    begin
                        conv_next  = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cls_next   = CLASS_FIRST;
                        idx_next   = '0;
                        err_next   = 1'b0;
                        state_next = S_READ;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    if (slot_reg == LAST_SLOT)
                        state_next = S_IDLE;
                    else
                        slot_next = slot_reg + SLOT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cls_reg       <= CLASS_FIRST;
            idx_reg       <= '0;
            slot_reg      <= '0;
            epoch_reg     <= '0;
            err_reg       <= 1'b0;
            conv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cls_reg       <= cls_next;
            idx_reg       <= idx_next;
            slot_reg      <= slot_next;
            epoch_reg     <= epoch_next;
            err_reg       <= err_next;
            conv_reg      <= conv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### design/two_class_perceptron_trainer.sv
// Top level of the two-class perceptron trainer: APB register file, controller, datapath.
// Depends on tpt_pkg, tpt_ctrl and tpt_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready/in_item): a load transaction (command 0) writes one
//   four-feature sample into the store; loads are taken back to back.
//   A start transaction (command 1) runs training and blocks the input until the
//   last result is loaded into the output register.
//   Training: a setup step, then per visited sample a memory read, five
//   multiply-accumulate steps on one shared multiplier, a final add, and a decide
//   and update step.
//   Output channel (out_valid/out_ready/out_item): five transactions, one per weight
//   slot, the last flagged by last_result.
//   A stalled receiver holds the output register and halts the drain; the next
//   transaction on the input is taken once the last slot sits in the output register.
//   Reset returns the controller to idle with no result pending and the registers to
//   their defaults; sample memory is not cleared and must be loaded before use.
//   Configuration is written over APB at byte address 4*i; write only while idle.
`timescale 1ns / 1ps

module two_class_perceptron_trainer
    import tpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [EPOCH_W-1:0]      max_epochs_reg;
    logic [SPC_W-1:0]        samples_reg;
    logic signed [INIT_W-1:0] init_first_reg;
    logic signed [INIT_W-1:0] init_second_reg;
    logic [RATE_W-1:0]       rate_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    tpt_cmd_t    cmd;
    tpt_status_t status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_epochs_reg  <= EPOCH_W'(10000);
            samples_reg     <= SPC_W'(50);
            init_first_reg  <= INIT_W'(4);
            init_second_reg <= '0;
            rate_reg        <= RATE_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MAX_EPOCHS:  max_epochs_reg  <= pwdata[EPOCH_W-1:0];
                REG_SAMPLES:     samples_reg     <= pwdata[SPC_W-1:0];
                REG_INIT_FIRST:  init_first_reg  <= pwdata[INIT_W-1:0];
                REG_INIT_SECOND: init_second_reg <= pwdata[INIT_W-1:0];
                REG_RATE:        rate_reg        <= pwdata[RATE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MAX_EPOCHS:  prdata = 32'(max_epochs_reg);
            REG_SAMPLES:     prdata = 32'(samples_reg);
            REG_INIT_FIRST:  prdata = 32'(init_first_reg);
            REG_INIT_SECOND: prdata = 32'(init_second_reg);
            REG_RATE:        prdata = 32'(rate_reg);
            default:         prdata = '0;
        endcase
    end

    tpt_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_command        (in_item.command),
        .in_ready          (in_ready),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .max_epochs        (max_epochs_reg),
        .samples_per_class (samples_reg),
        .status            (status),
        .cmd               (cmd)
    );

    tpt_datapath u_datapath (
        .clk                (clk),
        .cmd                (cmd),
        .in_item            (in_item),
        .rate_mult          (rate_reg),
        .init_first_weight  (init_first_reg),
        .init_second_weight (init_second_reg),
        .status             (status),
        .out_item           (out_item)
    );

`ifndef SYNTHESIS
    a_load_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_wr |-> (in_valid && in_ready && (in_item.command == CMD_LOAD)))
        else $error("sample write without an accepted load transaction");

    a_no_read_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_rd |-> !in_ready)
        else $error("training read while input is open");

    a_drain_ends_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_item.last_result) |=> !out_valid)
        else $error("result presented after the final slot");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.weight_slot <= LAST_SLOT))
        else $error("weight slot out of range");
`endif

endmodule

### tb/tb_two_class_perceptron_trainer.sv
// Testbench for two_class_perceptron_trainer: loads samples, runs training passes and
// checks every weight-slot result against an in-bench perceptron scoreboard.
// Depends on tpt_pkg and the two_class_perceptron_trainer RTL.
`timescale 1ns / 1ps

module tb_two_class_perceptron_trainer;
    import tpt_pkg::*;

    localparam int     ITEM_TARGET   = 430;
    localparam int     RUN_BUDGET    = 6000;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     CYCLE_LIMIT   = 20_000_000;
    localparam longint WEIGHT_HI     = 64'sd2147483647;
    localparam longint WEIGHT_LO     = -64'sd2147483648;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_item  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    bit          idle_on     = 1'b1;
    int unsigned cycle_count = 0;

    class perceptron_scoreboard;
        bit [FEAT_BITS-1:0]     sample_mem [2*MAX_PER_CLASS][FEATURES];
        bit                     written [2*MAX_PER_CLASS];
        bit [EPOCH_W-1:0]       cfg_max_epochs  = 16'd10000;
        bit [SPC_W-1:0]         cfg_samples     = 7'd50;
        bit signed [INIT_W-1:0] cfg_init_first  = 16'sd4;
        bit signed [INIT_W-1:0] cfg_init_second = 16'sd0;
        bit [RATE_W-1:0]        cfg_rate        = 8'd1;
        longint                 run_first [SLOTS];
        longint                 run_second [SLOTS];
        bit                     run_converged;
        int unsigned            run_epoch;
        out_item_t              expected_weights [$];
        int unsigned            error_count;
        int unsigned            checked_count;
        int unsigned            load_count;
        int unsigned            start_count;
        int unsigned            converged_count;

        function void set_register(logic [2:0] index, logic [31:0] value);
            case (index)
                REG_MAX_EPOCHS:  cfg_max_epochs  = value[EPOCH_W-1:0];
                REG_SAMPLES:     cfg_samples     = value[SPC_W-1:0];
                REG_INIT_FIRST:  cfg_init_first  = value[INIT_W-1:0];
                REG_INIT_SECOND: cfg_init_second = value[INIT_W-1:0];
                REG_RATE:        cfg_rate        = value[RATE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned used_samples();
            return (cfg_samples > MAX_PER_CLASS) ? MAX_PER_CLASS : int'(cfg_samples);
        endfunction

        function longint augmented(int entry, int slot);
            return (slot == 0) ? longint'(BIAS_INPUT) : longint'(sample_mem[entry][slot-1]);
        endfunction

        function longint clamp_weight(longint v);
            if (v > WEIGHT_HI)
                return WEIGHT_HI;
            if (v < WEIGHT_LO)
                return WEIGHT_LO;
            return v;
        endfunction

        // Train both vectors under the current settings; return the epochs visited.
        function int unsigned train_vectors();
            int unsigned n;
            int unsigned hits;
            int          entry;
            longint      score;
            longint      step;
            bit          own_first;
            n = used_samples();
            for (int j = 0; j < SLOTS; j++)
            begin
                run_first[j]  = cfg_init_first;
                run_second[j] = cfg_init_second;
            end
            run_converged = 1'b0;
            run_epoch     = 0;
            while (run_epoch < cfg_max_epochs)
            begin
                hits = 0;
                for (int k = 0; k < int'(2 * n); k++)
                begin
                    own_first = (k < int'(n));
                    entry     = own_first ? k : MAX_PER_CLASS + k - int'(n);
                    score     = 0;
                    for (int j = 0; j < SLOTS; j++)
                        score += (run_first[j] - run_second[j]) * augmented(entry, j);
                    if (own_first ? (score > 0) : (score < 0))
                        hits++;
                    else
                    begin
                        for (int j = 0; j < SLOTS; j++)
                        begin
                            step = longint'(cfg_rate) * augmented(entry, j);
                            if (!own_first)
                                step = -step;
                            run_first[j]  = clamp_weight(run_first[j] + step);
                            run_second[j] = clamp_weight(run_second[j] - step);
                        end
                    end
                end
                if (hits == 2 * n)
                begin
                    run_converged = 1'b1;
                    break;
                end
                run_epoch++;
            end
            return run_converged ? run_epoch + 1 : run_epoch;
        endfunction

        function void note_transaction(in_item_t item);
            out_item_t slot_item;
            int        entry;
            if (item.command == CMD_LOAD)
            begin
                entry = int'(item.sample_class) * MAX_PER_CLASS + int'(item.sample_index);
                sample_mem[entry][0] = item.feature_a;
                sample_mem[entry][1] = item.feature_b;
                sample_mem[entry][2] = item.feature_c;
                sample_mem[entry][3] = item.feature_d;
                written[entry]       = 1'b1;
                load_count++;
            end
            else
            begin
                void'(train_vectors());
                start_count++;
                if (run_converged)
                    converged_count++;
                for (int j = 0; j < SLOTS; j++)
                begin
                    slot_item.converged     = run_converged;
                    slot_item.epoch_count   = run_epoch[EPOCH_W-1:0];
                    slot_item.weight_slot   = SLOT_W'(j);
                    slot_item.first_weight  = run_first[j][WEIGHT_BITS-1:0];
                    slot_item.second_weight = run_second[j][WEIGHT_BITS-1:0];
                    slot_item.last_result   = (j == SLOTS - 1);
                    expected_weights.push_back(slot_item);
                end
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_weights.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result slot=%0d w1=%0d w2=%0d", $time,
                         got.weight_slot, got.first_weight, got.second_weight);
                return;
            end
            want = expected_weights.pop_front();
            checked_count++;
            if (got !== want)
            begin
                error_count++;
                $display({"%0t: mismatch expected conv=%0d epoch=%0d slot=%0d w1=%0d w2=%0d ",
                          "last=%0d, actual conv=%0d epoch=%0d slot=%0d w1=%0d w2=%0d last=%0d"},
                         $time, want.converged, want.epoch_count, want.weight_slot,
                         want.first_weight, want.second_weight, want.last_result,
                         got.converged, got.epoch_count, got.weight_slot,
                         got.first_weight, got.second_weight, got.last_result);
            end
        endfunction

        function int pending();
            return expected_weights.size();
        endfunction
    endclass

    perceptron_scoreboard sb;

    two_class_perceptron_trainer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            sb.check_result(out_item);
        out_ready <= !(idle_on && $urandom_range(0, 99) < 18);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(input in_item_t item);
        if (idle_on && $urandom_range(0, 99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        sb.note_transaction(item);
    endtask

    task automatic send_load(input logic cls, input logic [IDX_W-1:0] idx,
                             input logic [31:0] feats);
        in_item_t item;
        item              = '0;
        item.command      = CMD_LOAD;
        item.sample_class = cls;
        item.sample_index = idx;
        {item.feature_a, item.feature_b, item.feature_c, item.feature_d} = feats;
        send_item(item);
    endtask

    task automatic send_start();
        logic [63:0] noise;
        in_item_t    item;
        noise        = {$urandom, $urandom};
        item         = noise[$bits(in_item_t)-1:0];
        item.command = CMD_START;
        send_item(item);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(index, value);
        @(posedge clk);
    endtask

    // Drop valid, wait out pending results, then let the pipeline go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_features(int mode, logic cls);
        logic [31:0] f;
        int          v;
        f = '0;
        for (int i = 0; i < 4; i++)
        begin
            case (mode)
                0:       v = (cls == CLASS_FIRST) ? $urandom_range(140, 255)
                                                  : $urandom_range(0, 115);
                1:       v = $urandom_range(0, 255);
                default: v = $urandom_range(0, 1) ? 255 : 0;
            endcase
            f = {f[23:0], 8'(v)};
        end
        return f;
    endfunction

    function automatic logic [31:0] pick_epochs();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'd0;
        if (r < 10)
            return 32'd65535;
        if (r < 15)
            return 32'd1;
        return 32'($urandom_range(2, 40));
    endfunction

    function automatic logic [31:0] pick_init();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'h0000_8000;
        if (r < 20)
            return 32'h0000_7FFF;
        if (r < 60)
            return {16'h0000, 16'($urandom_range(0, 40)) - 16'd20};
        return {16'h0000, 16'($urandom)};
    endfunction

    function automatic logic [31:0] pick_rate();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'd0;
        if (r < 15)
            return 32'd1;
        if (r < 25)
            return 32'd255;
        return 32'($urandom_range(1, 255));
    endfunction

    initial
    begin
        int          n_cfg;
        int          n_used;
        int          mode;
        int          r;
        int unsigned visited;
        int unsigned base;
        int unsigned done_items;
        bit          wide_done;

        sb        = new();
        wide_done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Separable pair, huge epoch limit, default weights and rate.
        write_register(REG_SAMPLES, 32'd1);
        write_register(REG_MAX_EPOCHS, 32'd65535);
        send_load(CLASS_FIRST, 6'd0, 32'hFFFF_FFFF);
        send_load(CLASS_SECOND, 6'd0, 32'h0000_0000);
        send_start();
        send_load(CLASS_FIRST, 6'd63, 32'h55AA_33CC);
        send_load(CLASS_SECOND, 6'd63, 32'hAA55_CC33);
        settle();
        write_register(REG_SAMPLES, 32'd0);
        send_start();
        settle();
        write_register(REG_SAMPLES, 32'd1);
        write_register(REG_MAX_EPOCHS, 32'd0);
        write_register(REG_INIT_FIRST, 32'h0000_8000);
        write_register(REG_INIT_SECOND, 32'h0000_7FFF);
        write_register(REG_RATE, 32'd255);
        send_start();
        // Contradicting pair: the run hits the epoch limit.
        send_load(CLASS_FIRST, 6'd1, 32'h0000_0000);
        send_load(CLASS_SECOND, 6'd1, 32'hFFFF_FFFF);
        settle();
        write_register(REG_SAMPLES, 32'd2);
        write_register(REG_MAX_EPOCHS, 32'd3);
        write_register(REG_INIT_FIRST, 32'd0);
        write_register(REG_INIT_SECOND, 32'd0);
        write_register(REG_RATE, 32'd1);
        send_start();
        settle();
        write_register(REG_RATE, 32'd0);
        write_register(REG_MAX_EPOCHS, 32'd2);
        send_start();

        base = sb.load_count + sb.start_count;
        done_items = 0;
        while (done_items < ITEM_TARGET)
        begin
            idle_on = !(done_items >= 150 && done_items < 260);
            r = $urandom_range(0, 99);
            if (!wide_done && done_items >= 60)
            begin
                wide_done = 1'b1;
                n_cfg     = $urandom_range(64, 127);
            end
            else if (r < 6)
                n_cfg = 0;
            else if (r < 12)
                n_cfg = $urandom_range(9, 24);
            else
                n_cfg = $urandom_range(1, 8);
            n_used = (n_cfg > MAX_PER_CLASS) ? MAX_PER_CLASS : n_cfg;
            mode   = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);

            for (int i = 0; i < n_used; i++)
                for (int c = 0; c < 2; c++)
                    if (!sb.written[c * MAX_PER_CLASS + i] || $urandom_range(0, 99) < 85)
                        send_load(c[0], i[IDX_W-1:0], pick_features(mode, c[0]));
            repeat ($urandom_range(0, 2))
                send_load(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 63)),
                          pick_features(1, CLASS_FIRST));
            settle();

            write_register(REG_SAMPLES, 32'(n_cfg));
            if ($urandom_range(0, 1))
                write_register(REG_MAX_EPOCHS, pick_epochs());
            if ($urandom_range(0, 1))
                write_register(REG_INIT_FIRST, pick_init());
            if ($urandom_range(0, 1))
                write_register(REG_INIT_SECOND, pick_init());
            if ($urandom_range(0, 1))
                write_register(REG_RATE, pick_rate());
            // Hold each training pass to a bounded length.
            visited = sb.train_vectors();
            if (visited * 16 * n_used > RUN_BUDGET)
                write_register(REG_MAX_EPOCHS, 32'(RUN_BUDGET / (16 * n_used)));
            send_start();
            done_items = sb.load_count + sb.start_count - base;
        end

        idle_on = 1'b1;
        settle();
        $display("Run covered %0d sample loads and %0d training passes, %0d of them converged.",
                 sb.load_count, sb.start_count, sb.converged_count);
        $display("Weight-slot results checked: %0d, mismatches: %0d.",
                 sb.checked_count, sb.error_count);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### two_class_perceptron_trainer.f
design/tpt_pkg.sv
design/tpt_datapath.sv
design/tpt_ctrl.sv
design/two_class_perceptron_trainer.sv
tb/tb_two_class_perceptron_trainer.sv
